/* rtl/ucd_pkg.sv */
package ucd_pkg;

	// Pipeline depth: input register through result register
	localparam int unsigned NUM_STAGES = 8;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;
	// Start of era 5 (2000-03-01) and era 4, in days from 0000-03-01
	localparam logic [19:0] ERA5_START    = 20'd730485;
	localparam logic [19:0] ERA4_START    = 20'd584388;
	localparam logic [17:0] DAYS_PER_CENT = 18'd36524;
	localparam logic [17:0] LAST_DOE      = 18'd146096;
	localparam logic [11:0] ERA4_YEAR     = 12'd1600;
	localparam logic [11:0] ERA5_YEAR     = 12'd2000;

	// Reciprocals for division by constants, exact over the operand range used
	localparam logic [25:0] DAY_RECIP   = 26'd50903317; // x/675,  x < 2^25, >> 35
	localparam logic [13:0] HOUR_RECIP  = 14'd9321;     // x/225,  x < 2^13, >> 21
	localparam logic [16:0] WEEK_RECIP  = 17'd74899;    // x/7,    x < 2^16, >> 19
	localparam logic [16:0] QUAD_RECIP  = 17'd91930;    // x/365,  x < 2^16, >> 25
	localparam logic [18:0] YEAR_RECIP  = 19'd367720;   // x/365,  x < 2^18, >> 27
	localparam logic [9:0]  CENT_RECIP  = 10'd656;      // x/100,  x < 2^9,  >> 16
	localparam logic [11:0] MONTH_RECIP = 12'd3427;     // x/153,  x < 2^11, >> 19

	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_OCT = 4'd10;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} ucd_pipe_ctl_t;

	// First day of year-of-March index for each month index (March is 0)
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

/* rtl/ucd_dst_rule.sv */
module ucd_dst_rule import ucd_pkg::*; (
	input  logic [3:0] month_number,
	input  logic [4:0] day_of_month,
	input  logic [2:0] weekday,
	input  logic [4:0] hour_of_day,
	output logic       summer_time
);

	logic in_season;
	logic last_week;
	logic past_switch;

	always_comb begin
		in_season   = month_number inside {[MONTH_MAR:MONTH_OCT]};
		// Last Sunday is reached once day - weekday >= 25
		last_week   = {1'b0, day_of_month} >= ({3'b0, weekday} + 6'd25);
		past_switch = last_week && ((weekday != 3'd0) || (hour_of_day >= 5'd2));
		if (!in_season) begin
			summer_time = 1'b0;
		end else if (past_switch) begin
			summer_time = (month_number != MONTH_OCT);
		end else begin
			summer_time = (month_number != MONTH_MAR);
		end
	end

endmodule

/* rtl/ucd_pipe_ctl.sv */
module ucd_pipe_ctl import ucd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ts_valid,
	output logic          ts_ready,
	output logic          date_valid,
	input  logic          date_ready,
	output ucd_pipe_ctl_t ctl
);

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES:0]   rdy;
	logic [NUM_STAGES-1:0] vin;

	// A stage takes new data when it is empty or its own content moves on
	always_comb begin
		vin = {valid_q[NUM_STAGES-2:0], ts_valid};
		rdy[NUM_STAGES] = date_ready;
		for (int i = NUM_STAGES - 1; i >= 0; i--) begin
			rdy[i] = !valid_q[i] || rdy[i+1];
		end
		for (int i = 0; i < NUM_STAGES; i++) begin
			ctl.load[i] = rdy[i] && vin[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				if (rdy[i]) begin
					valid_q[i] <= vin[i];
				end
			end
		end
	end

	assign ts_ready   = rdy[0];
	assign date_valid = valid_q[NUM_STAGES-1];

endmodule

/* rtl/ucd_datapath.sv */
module ucd_datapath import ucd_pkg::*; (
	input  logic          clk,
	input  ucd_pipe_ctl_t ctl,
	input  logic [31:0]   local_seconds,
	output logic          summer_time,
	output logic [4:0]    day_of_month,
	output logic [3:0]    month_number,
	output logic [11:0]   year_number,
	output logic [4:0]    hour_of_day,
	output logic [2:0]    weekday
);

	// Stage 1: input register
	logic [31:0] secs_s1;

	// Stage 2: day count
	logic [50:0] day_prod;
	logic [15:0] days_s2;
	logic [31:0] secs_s2;

	// Stage 3: second of day, day of era
	logic [31:0] day_secs;
	logic [31:0] rem_full;
	logic [19:0] z;
	logic        era5;
	logic [19:0] doe_full;
	logic [16:0] rem_s3;
	logic [15:0] days_s3;
	logic [17:0] doe_s3;
	logic        era5_s3;

	// Stage 4: hour, week quotient, leap-corrected day of era
	logic [26:0] hour_prod;
	logic [15:0] days4;
	logic [32:0] week_prod;
	logic [32:0] quad_prod;
	logic [2:0]  cents;
	logic        last_doe;
	logic [17:0] t;
	logic [4:0]  hour_s4;
	logic [15:0] days4_s4;
	logic [12:0] q7_s4;
	logic [17:0] t_s4;
	logic [17:0] doe_s4;
	logic        era5_s4;

	// Stage 5: weekday, year of era
	logic [15:0] q7x7;
	logic [15:0] wk;
	logic [36:0] yoe_prod;
	logic [2:0]  wday_s5;
	logic [4:0]  hour_s5;
	logic [8:0]  yoe_s5;
	logic [17:0] doe_s5;
	logic        era5_s5;

	// Stage 6: day of year
	logic [18:0] cent_prod;
	logic [17:0] ydays;
	logic [17:0] doy_full;
	logic [8:0]  doy_s6;
	logic [8:0]  yoe_s6;
	logic        era5_s6;
	logic [2:0]  wday_s6;
	logic [4:0]  hour_s6;

	// Stage 7: month index
	logic [10:0] mp_num;
	logic [22:0] mp_prod;
	logic [3:0]  mp_s7;
	logic [8:0]  doy_s7;
	logic [8:0]  yoe_s7;
	logic        era5_s7;
	logic [2:0]  wday_s7;
	logic [4:0]  hour_s7;

	// Stage 8: result register
	logic [8:0]  dom_full;
	logic [4:0]  dom;
	logic [3:0]  mon;
	logic [11:0] year;
	logic        summer;
	logic        summer_s8;
	logic [4:0]  dom_s8;
	logic [3:0]  mon_s8;
	logic [11:0] year_s8;
	logic [4:0]  hour_s8;
	logic [2:0]  wday_s8;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			secs_s1 <= local_seconds;
		end
	end

	// days = secs / 86400 = (secs >> 7) / 675
	assign day_prod = 51'(secs_s1[31:7]) * 51'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			days_s2 <= day_prod[50:35];
			secs_s2 <= secs_s1;
		end
	end

	// Day counts from 1970 only reach era 4 or era 5
	always_comb begin
		day_secs = 32'(days_s2) * 32'(SECS_PER_DAY);
		rem_full = secs_s2 - day_secs;
		z        = {4'b0, days_s2} + DAYS_TO_EPOCH;
		era5     = z >= ERA5_START;
		doe_full = z - (era5 ? ERA5_START : ERA4_START);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			rem_s3  <= rem_full[16:0];
			days_s3 <= days_s2;
			doe_s3  <= doe_full[17:0];
			era5_s3 <= era5;
		end
	end

	always_comb begin
		hour_prod = 27'(rem_s3[16:4]) * 27'(HOUR_RECIP);
		days4     = days_s3 + 16'd4;
		week_prod = 33'(days4) * 33'(WEEK_RECIP);
		quad_prod = 33'(doe_s3[17:2]) * 33'(QUAD_RECIP);
		cents     = 3'(doe_s3 >= DAYS_PER_CENT) + 3'(doe_s3 >= 18'(2 * DAYS_PER_CENT))
		          + 3'(doe_s3 >= 18'(3 * DAYS_PER_CENT)) + 3'(doe_s3 >= LAST_DOE);
		last_doe  = doe_s3 == LAST_DOE;
		t         = doe_s3 - 18'(quad_prod[32:25]) + 18'(cents) - 18'(last_doe);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			hour_s4  <= hour_prod[25:21];
			days4_s4 <= days4;
			q7_s4    <= week_prod[31:19];
			t_s4     <= t;
			doe_s4   <= doe_s3;
			era5_s4  <= era5_s3;
		end
	end

	always_comb begin
		q7x7     = {q7_s4, 3'b0} - {3'b0, q7_s4};
		wk       = days4_s4 - q7x7;
		yoe_prod = 37'(t_s4) * 37'(YEAR_RECIP);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			wday_s5 <= wk[2:0];
			hour_s5 <= hour_s4;
			yoe_s5  <= yoe_prod[35:27];
			doe_s5  <= doe_s4;
			era5_s5 <= era5_s4;
		end
	end

	always_comb begin
		cent_prod = 19'(yoe_s5) * 19'(CENT_RECIP);
		ydays     = 18'(yoe_s5) * 18'd365 + 18'(yoe_s5[8:2]) - 18'(cent_prod[17:16]);
		doy_full  = doe_s5 - ydays;
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			doy_s6  <= doy_full[8:0];
			yoe_s6  <= yoe_s5;
			era5_s6 <= era5_s5;
			wday_s6 <= wday_s5;
			hour_s6 <= hour_s5;
		end
	end

	always_comb begin
		mp_num  = ({2'b0, doy_s6} * 11'd5) + 11'd2;
		mp_prod = 23'(mp_num) * 23'(MONTH_RECIP);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			mp_s7   <= mp_prod[22:19];
			doy_s7  <= doy_s6;
			yoe_s7  <= yoe_s6;
			era5_s7 <= era5_s6;
			wday_s7 <= wday_s6;
			hour_s7 <= hour_s6;
		end
	end

	// Month index counts from March; Jan and Feb belong to the next year
	always_comb begin
		dom_full = doy_s7 - month_start(mp_s7) + 9'd1;
		dom      = dom_full[4:0];
		mon      = (mp_s7 < 4'd10) ? (mp_s7 + 4'd3) : (mp_s7 - 4'd9);
		year     = (era5_s7 ? ERA5_YEAR : ERA4_YEAR) + {3'b0, yoe_s7}
		         + 12'(mon <= 4'd2);
	end

	ucd_dst_rule u_dst (
		.month_number (mon),
		.day_of_month (dom),
		.weekday      (wday_s7),
		.hour_of_day  (hour_s7),
		.summer_time  (summer)
	);

	always_ff @(posedge clk) begin
		if (ctl.load[7]) begin
			summer_s8 <= summer;
			dom_s8    <= dom;
			mon_s8    <= mon;
			year_s8   <= year;
			hour_s8   <= hour_s7;
			wday_s8   <= wday_s7;
		end
	end

	assign summer_time  = summer_s8;
	assign day_of_month = dom_s8;
	assign month_number = mon_s8;
	assign year_number  = year_s8;
	assign hour_of_day  = hour_s8;
	assign weekday      = wday_s8;

endmodule

/* rtl/unix_time_to_date_and_dst.sv */
// Channel | Direction | Handshake              | Payload
// ts      | in        | ts_valid / ts_ready     | local_seconds[31:0]
// date    | out       | date_valid / date_ready | summer_time, day_of_month, month_number,
//         |           |                         | year_number, hour_of_day, weekday
//
// One transaction per cycle sustained while date_ready stays high; a timestamp
// passes through the eight register stages of the datapath, input register
// through result register, before it shows up as a valid result.
// Each stage has its own valid bit, so a stalled result holds only the last
// stage and bubbles further up are still filled while date_ready is low.
// arst_n clears the valid bits only; data registers are not reset.
module unix_time_to_date_and_dst import ucd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ts_valid,
	output logic        ts_ready,
	input  logic [31:0] local_seconds,
	output logic        date_valid,
	input  logic        date_ready,
	output logic        summer_time,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_number,
	output logic [11:0] year_number,
	output logic [4:0]  hour_of_day,
	output logic [2:0]  weekday
);

	ucd_pipe_ctl_t ctl;

	// Valid tracking and per-stage load enables
	ucd_pipe_ctl u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.ts_valid   (ts_valid),
		.ts_ready   (ts_ready),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.ctl        (ctl)
	);

	// Split seconds into day and hour, then day count into civil date,
	// weekday and summer-time flag
	ucd_datapath u_dp (
		.clk           (clk),
		.ctl           (ctl),
		.local_seconds (local_seconds),
		.summer_time   (summer_time),
		.day_of_month  (day_of_month),
		.month_number  (month_number),
		.year_number   (year_number),
		.hour_of_day   (hour_of_day),
		.weekday       (weekday)
	);

endmodule

/* rtl/ucd_checker.sv */
module ucd_checker import ucd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        ts_valid,
	input logic        ts_ready,
	input logic        date_valid,
	input logic        date_ready,
	input logic        summer_time,
	input logic [4:0]  day_of_month,
	input logic [3:0]  month_number,
	input logic [11:0] year_number,
	input logic [4:0]  hour_of_day,
	input logic [2:0]  weekday
);

	logic [3:0] pending_q;
	logic       ts_acc;
	logic       date_acc;

	assign ts_acc   = ts_valid && ts_ready;
	assign date_acc = date_valid && date_ready;

	// Count transactions in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 4'(ts_acc) - 4'(date_acc);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		date_valid && !date_ready |=> date_valid && $stable(year_number)
		&& $stable(month_number) && $stable(day_of_month) && $stable(summer_time))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		date_valid |-> pending_q != 4'd0)
		else $error("result without a pending transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(NUM_STAGES))
		else $error("more transactions in flight than stages");

	assert property (@(posedge clk) disable iff (!arst_n)
		date_valid |-> month_number >= 4'd1 && month_number <= 4'd12
		&& day_of_month >= 5'd1 && hour_of_day <= 5'd23 && weekday <= 3'd6
		&& year_number >= 12'd1970 && year_number <= 12'd2106)
		else $error("result field out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		date_valid && summer_time |-> month_number >= MONTH_MAR
		&& month_number <= MONTH_OCT)
		else $error("summer time outside March to October");

endmodule

bind unix_time_to_date_and_dst ucd_checker u_ucd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.ts_valid     (ts_valid),
	.ts_ready     (ts_ready),
	.date_valid   (date_valid),
	.date_ready   (date_ready),
	.summer_time  (summer_time),
	.day_of_month (day_of_month),
	.month_number (month_number),
	.year_number  (year_number),
	.hour_of_day  (hour_of_day),
	.weekday      (weekday)
);

/* test/tb_top.sv */
module tb_top;
	import ucd_pkg::*;

	localparam int unsigned DAY_SECS  = 86400;
	localparam int unsigned HOUR_SECS = 3600;
	localparam int unsigned EPOCH_DAY = 719468;  // days from 0000-03-01 to 1970-01-01
	localparam int unsigned ERA_DAYS  = 146097;
	localparam int unsigned SWITCH_HR = 2;       // clocks change at 02:00 local
	localparam int unsigned RAND_ITEMS = 700;

	localparam logic [2:0] SUNDAY   = 3'd0;
	localparam logic [2:0] THURSDAY = 3'd4;

	typedef struct packed {
		logic        summer;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [4:0]  hour;
		logic [2:0]  wday;
	} date_t;

	// One directed transaction; typed rows carry a hand-written expectation
	typedef struct {
		logic [31:0] secs;
		bit          typed;
		date_t       date;
	} stim_row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        ts_valid      = 1'b0;
	logic        ts_ready;
	logic [31:0] local_seconds = '0;
	logic        date_valid;
	logic        date_ready    = 1'b0;
	logic        summer_time;
	logic [4:0]  day_of_month;
	logic [3:0]  month_number;
	logic [11:0] year_number;
	logic [4:0]  hour_of_day;
	logic [2:0]  weekday;

	// Expectation that belongs to the timestamp currently offered on the ts channel
	date_t       pending_date = '0;
	date_t       date_q [$];
	stim_row_t   stim_table [$];
	int          errors    = 0;
	int unsigned send_idle = 16;
	int unsigned recv_idle = 75;

	unix_time_to_date_and_dst dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.ts_valid     (ts_valid),
		.ts_ready     (ts_ready),
		.local_seconds(local_seconds),
		.date_valid   (date_valid),
		.date_ready   (date_ready),
		.summer_time  (summer_time),
		.day_of_month (day_of_month),
		.month_number (month_number),
		.year_number  (year_number),
		.hour_of_day  (hour_of_day),
		.weekday      (weekday)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Civil date, hour, weekday and EU summer-time flag for one timestamp.
	// The date uses 400-year eras with years starting on 1 March, so the
	// leap day falls at the end of the year and month lengths follow a
	// fixed 153-day pattern over each five months.
	function automatic date_t predict_date(input logic [31:0] secs);
		int unsigned days, hr, wd, z, era, doe, yoe, doy, mp, d, m, y;
		bit          past_switch;
		date_t       r;
		days = secs / DAY_SECS;
		hr   = (secs % DAY_SECS) / HOUR_SECS;
		// 1970-01-01 was a Thursday
		wd   = (days + 4) % 7;
		z    = days + EPOCH_DAY;
		era  = z / ERA_DAYS;
		doe  = z - era * ERA_DAYS;
		yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp   = (5 * doy + 2) / 153;
		d    = doy - (153 * mp + 2) / 5 + 1;
		m    = (mp < 10) ? mp + 3 : mp - 9;
		y    = era * 400 + yoe + ((m <= 2) ? 1 : 0);
		if (m < MONTH_MAR || m > MONTH_OCT) begin
			r.summer = 1'b0;
		end else begin
			// On or after the last Sunday of the month, from 02:00 on that Sunday.
			// Within 7 days of month end, day - weekday >= 25 marks that point.
			past_switch = (int'(d) - int'(wd) >= 25) && (wd != SUNDAY || hr >= SWITCH_HR);
			if (past_switch)
				r.summer = (m != MONTH_OCT);
			else
				r.summer = (m != MONTH_MAR);
		end
		r.day   = d[4:0];
		r.month = m[3:0];
		r.year  = y[11:0];
		r.hour  = hr[4:0];
		r.wday  = wd[2:0];
		return r;
	endfunction

	// Day count since 1970 for a date in March or later of its year
	function automatic longint unsigned days_since_epoch(input int unsigned y,
			input int unsigned m, input int unsigned d);
		int unsigned era, yoe, doy, doe;
		era = y / 400;
		yoe = y - era * 400;
		doy = (153 * (m - 3) + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return longint'(era) * ERA_DAYS + doe - EPOCH_DAY;
	endfunction

	function automatic int field_diff(input string name, input int unsigned want,
			input int unsigned got);
		if (want == got)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1;
	endfunction

	// Offer one timestamp: idle first at the current rate, then hold valid and
	// payload until the transaction goes through
	task automatic send_ts(input logic [31:0] secs, input date_t want);
		while ($urandom_range(0, 99) < send_idle) begin
			ts_valid <= 1'b0;
			@(posedge clk);
		end
		ts_valid      <= 1'b1;
		local_seconds <= secs;
		pending_date  <= want;
		@(posedge clk);
		while (!ts_ready)
			@(posedge clk);
	endtask

	// Random timestamp: half the time anywhere in the range, often inside the last
	// week of March or October around the 02:00 switch, sometimes at the ends
	function automatic logic [31:0] random_ts();
		int unsigned     pick, y, m, d;
		longint unsigned secs;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return $urandom;
		if (pick == 9)
			return $urandom_range(0, 1) ? $urandom_range(0, 1000000)
				: 32'hFFFF_FFFF - $urandom_range(0, 1000000);
		y    = $urandom_range(1970, 2105);
		m    = $urandom_range(0, 1) ? MONTH_OCT : MONTH_MAR;
		d    = $urandom_range(24, 31);
		secs = days_since_epoch(y, m, d) * DAY_SECS
			+ $urandom_range(0, 3) * HOUR_SECS + $urandom_range(0, HOUR_SECS - 1);
		return secs[31:0];
	endfunction

	// Receiver: drop date_ready at the current idle rate
	always @(posedge clk)
		date_ready <= ($urandom_range(0, 99) >= recv_idle);

	// Scoreboard: check each result against the oldest expectation, then queue
	// the expectation of a timestamp accepted at this edge
	always @(posedge clk) begin : scoreboard
		date_t want;
		if (date_valid && date_ready) begin
			if (date_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d-%0d-%0d h%0d",
					$time, year_number, month_number, day_of_month, hour_of_day);
				errors++;
			end else begin
				want = date_q.pop_front();
				errors += field_diff("summer_time", want.summer, summer_time);
				errors += field_diff("day_of_month", want.day, day_of_month);
				errors += field_diff("month_number", want.month, month_number);
				errors += field_diff("year_number", want.year, year_number);
				errors += field_diff("hour_of_day", want.hour, hour_of_day);
				errors += field_diff("weekday", want.wday, weekday);
			end
		end
		if (ts_valid && ts_ready)
			date_q.push_back(pending_date);
	end

	initial begin
		// Extremes of the range
		stim_table.push_back('{32'd0, 1'b1, '{1'b0, 5'd1, 4'd1, 12'd1970, 5'd0, THURSDAY}});
		stim_table.push_back('{32'hFFFF_FFFF, 1'b1,
			'{1'b0, 5'd7, 4'd2, 12'd2106, 5'd6, SUNDAY}});
		stim_table.push_back('{32'd31535999, 1'b1,
			'{1'b0, 5'd31, 4'd12, 12'd1970, 5'd23, THURSDAY}});
		stim_table.push_back('{32'h7FFF_FFFF, 1'b0, '0});
		stim_table.push_back('{32'h8000_0000, 1'b0, '0});
		// Last Sunday of March 2021 (the 28th): winter until 02:00
		stim_table.push_back('{32'd1616886000, 1'b0, '0});
		stim_table.push_back('{32'd1616893200, 1'b0, '0});
		stim_table.push_back('{32'd1616896799, 1'b0, '0});
		stim_table.push_back('{32'd1616896800, 1'b0, '0});
		// Last Sunday of March 2024 falls on the 31st, of March 2018 on the 25th
		stim_table.push_back('{32'd1711846800, 1'b0, '0});
		stim_table.push_back('{32'd1711850400, 1'b0, '0});
		stim_table.push_back('{32'd1521939600, 1'b0, '0});
		stim_table.push_back('{32'd1521943200, 1'b0, '0});
		// Last Sunday of October 2021 (the 31st): summer until 02:00
		stim_table.push_back('{32'd1635642000, 1'b0, '0});
		stim_table.push_back('{32'd1635645599, 1'b0, '0});
		stim_table.push_back('{32'd1635645600, 1'b0, '0});
		stim_table.push_back('{32'd1635724799, 1'b0, '0});
		// Leap day 2000, and 2100, a century year without one
		stim_table.push_back('{32'd951782400, 1'b0, '0});
		stim_table.push_back('{32'd4107542399, 1'b0, '0});
		stim_table.push_back('{32'd4107542400, 1'b0, '0});

		// Hold reset at the start, then release on an edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send_ts(stim_table[i].secs, stim_table[i].typed ? stim_table[i].date
				: predict_date(stim_table[i].secs));

		// Sender idles lightly and receiver heavily, then the reverse, then
		// full rate on both sides
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 16 : (phase == 1) ? 75 : 0;
			recv_idle = (phase == 0) ? 75 : (phase == 1) ? 16 : 0;
			for (int n = 0; n < RAND_ITEMS / 3; n++) begin
				logic [31:0] secs;
				secs = random_ts();
				send_ts(secs, predict_date(secs));
			end
		end
		ts_valid <= 1'b0;

		// Drain the pipeline, then keep watching for stray results
		@(posedge clk);
		while (date_q.size() != 0)
			@(posedge clk);
		repeat (2 * NUM_STAGES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#200000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
